### src/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// Shared types, constants and a helper function of the route table engine.
// ----------------------------------------------------------------------------
package rte_pkg;

    localparam int Depth = 64;
    localparam int IdxW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    localparam logic [3:0] OP_LOAD = 4'd0;
    localparam logic [3:0] OP_APPEND = 4'd1;
    localparam logic [3:0] OP_FIND = 4'd2;
    localparam logic [3:0] OP_READ = 4'd3;
    localparam logic [3:0] OP_REMOVE = 4'd4;
    localparam logic [3:0] OP_UNREACH_HOP = 4'd5;
    localparam logic [3:0] OP_REMOVE_HOP = 4'd6;
    localparam logic [3:0] OP_UNREACH_NET = 4'd7;
    localparam logic [3:0] OP_ENABLE_NET = 4'd8;
    localparam logic [3:0] OP_DISABLE_NET = 4'd9;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [31:0] net;
        logic [5:0] prefix;
        logic [31:0] distance;
        logic via;
        logic [31:0] hop;
        logic disabled;
    } t_entry;

    localparam int EntryW = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic latch;      // capture request
        logic rd_en;      // issue table read
        logic [IdxW-1:0] rd_addr;
        logic wr_en;
        logic [IdxW-1:0] wr_addr;
        logic [1:0] wr_sel; // 0 new entry, 1 modified read data, 2 last entry data
        logic cnt_inc;
        logic cnt_dec;
        logic hold_last;  // capture read data as last entry
        logic set_hit;    // capture read data as result
        logic [IdxW-1:0] hit_idx;
        logic done;
        logic [1:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [3:0] op;
        logic [CntW-1:0] count;
        logic [IdxW-1:0] idx;
        logic match;      // registered read data matches
    } t_stat;

    localparam logic [1:0] WSEL_NEW = 2'd0;
    localparam logic [1:0] WSEL_MOD = 2'd1;
    localparam logic [1:0] WSEL_LAST = 2'd2;

    function automatic logic [31:0] prefix_mask(input logic [5:0] p);
        logic [31:0] m;
        m = 32'hFFFF_FFFF << (6'd32 - p);
        return (p == 6'd0) ? 32'd0 : m;
    endfunction

endpackage

### src/rte_ram.sv
// ----------------------------------------------------------------------------
// rte_ram
// Generic single port write, single port read RAM with registered read data.
// ----------------------------------------------------------------------------
module rte_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/rte_datapath.sv
// ----------------------------------------------------------------------------
// rte_datapath
// Request registers, entry count, route table memory and result registers.
// ----------------------------------------------------------------------------
module rte_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [3:0]                   i_opcode,
    input  logic [31:0]                  i_address_in,
    input  logic [5:0]                   i_prefix_in,
    input  logic [31:0]                  i_distance_in,
    input  logic [31:0]                  i_hop_in,
    input  logic [5:0]                   i_entry_index,
    input  logic                         i_cfg_we,
    input  logic [31:0]                  i_cfg_wdata,
    input  rte_pkg::t_cmd                i_cmd,
    output rte_pkg::t_stat               o_stat,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [5:0]                   o_hit_index,
    output logic [31:0]                  o_net_out,
    output logic [5:0]                   o_prefix_out,
    output logic [31:0]                  o_distance_out,
    output logic                         o_via_out,
    output logic [31:0]                  o_hop_out,
    output logic                         o_disabled_out,
    output logic [6:0]                   o_count_out
);
    logic [3:0] r_op;
    logic [31:0] r_addr, r_dist, r_hop, r_unreach;
    logic [5:0] r_pfx, r_idx;
    logic [rte_pkg::CntW-1:0] r_count;
    rte_pkg::t_entry r_last, rd_e, wr_e, mod_e, r_res;
    logic [rte_pkg::EntryW-1:0] rd_raw;
    logic r_valid;
    logic [1:0] r_status;
    logic [5:0] r_hit;
    logic [5:0] pfx_sat;

    assign pfx_sat = (i_prefix_in > 6'd32) ? 6'd32 : i_prefix_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_unreach <= 32'hFFFF_FFFF;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_unreach <= i_cfg_wdata;
            end
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - 1'b1;
            end
            r_valid <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op <= i_opcode;
            r_addr <= i_address_in;
            r_pfx <= pfx_sat;
            r_dist <= i_distance_in;
            r_hop <= i_hop_in;
            r_idx <= i_entry_index;
            r_res <= '0;
            r_hit <= '0;
        end
        if (i_cmd.hold_last) begin
            r_last <= rd_e;
        end
        if (i_cmd.set_hit) begin
            r_res <= rd_e;
            r_hit <= 6'(i_cmd.hit_idx);
        end
        if (i_cmd.done) begin
            r_status <= i_cmd.status;
        end
    end

    rte_ram #(.Width(rte_pkg::EntryW), .Depth(rte_pkg::Depth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (i_cmd.wr_addr),
        .i_wdata (wr_e),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rd_raw)
    );
    assign rd_e = rte_pkg::t_entry'(rd_raw);

    always_comb begin
        mod_e = rd_e;
        unique case (r_op)
            rte_pkg::OP_UNREACH_HOP, rte_pkg::OP_UNREACH_NET: mod_e.distance = r_unreach;
            rte_pkg::OP_ENABLE_NET: mod_e.disabled = 1'b0;
            rte_pkg::OP_DISABLE_NET: mod_e.disabled = 1'b1;
            default: mod_e = rd_e;
        endcase
    end

    always_comb begin
        wr_e = mod_e;
        unique case (i_cmd.wr_sel)
            rte_pkg::WSEL_NEW: begin
                wr_e.prefix = r_pfx;
                wr_e.distance = r_dist;
                wr_e.disabled = 1'b0;
                if (r_op == rte_pkg::OP_LOAD) begin
                    wr_e.net = r_addr & rte_pkg::prefix_mask(r_pfx);
                    wr_e.via = 1'b0;
                    wr_e.hop = '0;
                end else begin
                    wr_e.net = r_addr;
                    wr_e.via = 1'b1;
                    wr_e.hop = r_hop;
                end
            end
            rte_pkg::WSEL_MOD: wr_e = mod_e;
            rte_pkg::WSEL_LAST: wr_e = r_last;
            default: wr_e = mod_e;
        endcase
    end

    always_comb begin
        o_stat.op = r_op;
        o_stat.count = r_count;
        o_stat.idx = rte_pkg::IdxW'(r_idx);
        if (r_op == rte_pkg::OP_UNREACH_HOP || r_op == rte_pkg::OP_REMOVE_HOP) begin
            o_stat.match = rd_e.via && (rd_e.hop == r_hop);
        end else begin
            o_stat.match = (rd_e.net == r_addr);
        end
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_hit_index = r_hit;
    assign o_net_out = r_res.net;
    assign o_prefix_out = r_res.prefix;
    assign o_distance_out = r_res.distance;
    assign o_via_out = r_res.via;
    assign o_hop_out = r_res.hop;
    assign o_disabled_out = r_res.disabled;
    assign o_count_out = 7'(r_count);
endmodule

### src/rte_ctrl.sv
// ----------------------------------------------------------------------------
// rte_ctrl
// Sequencer for table operations: single entry accesses and linear scans.
// ----------------------------------------------------------------------------
module rte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  rte_pkg::t_stat i_stat,
    output rte_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_RD = 3'd2;  // read issued before; RAM read data register loaded
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_MVRD = 3'd4; // last entry read issued before; data in RAM read register
    localparam logic [2:0] S_MVWR = 3'd5;
    localparam logic [2:0] S_RECHK = 3'd6;

    logic [2:0] r_state, n_state;
    logic [rte_pkg::CntW-1:0] r_i, n_i;
    logic [rte_pkg::CntW-1:0] cnt;
    logic [3:0] op;
    logic scan, last_ok;

    assign cnt = i_stat.count;
    assign op = i_stat.op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign scan = (op == rte_pkg::OP_FIND) || (op >= rte_pkg::OP_UNREACH_HOP &&
                  op <= rte_pkg::OP_DISABLE_NET);

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        o_cmd = '0;
        last_ok = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch = i_start;
                if (i_start) begin
                    n_state = S_DISP;
                    n_i = '0;
                end
            end
            S_DISP: begin
                if (op == rte_pkg::OP_LOAD || op == rte_pkg::OP_APPEND) begin
                    n_state = S_IDLE;
                    o_cmd.done = 1'b1;
                    if (cnt >= rte_pkg::CntW'(rte_pkg::Depth)) begin
                        o_cmd.status = rte_pkg::ST_FULL;
                    end else begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wr_addr = rte_pkg::IdxW'(cnt);
                        o_cmd.wr_sel = rte_pkg::WSEL_NEW;
                        o_cmd.cnt_inc = 1'b1;
                    end
                end else if (op == rte_pkg::OP_READ || op == rte_pkg::OP_REMOVE) begin
                    if (rte_pkg::CntW'(i_stat.idx) >= cnt) begin
                        n_state = S_IDLE;
                        o_cmd.done = 1'b1;
                        o_cmd.status = rte_pkg::ST_RANGE;
                    end else if (op == rte_pkg::OP_READ) begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_addr = i_stat.idx;
                        n_i = rte_pkg::CntW'(i_stat.idx);
                        n_state = S_RD;
                    end else begin
                        n_i = rte_pkg::CntW'(i_stat.idx);
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_addr = rte_pkg::IdxW'(cnt - 1'b1);
                        n_state = S_MVRD;
                    end
                end else if (scan) begin
                    if (cnt == '0) begin
                        n_state = S_IDLE;
                        o_cmd.done = 1'b1;
                        o_cmd.status = (op == rte_pkg::OP_FIND) ?
                                       rte_pkg::ST_NOT_FOUND : rte_pkg::ST_OK;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_addr = '0;
                        n_state = S_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                    o_cmd.done = 1'b1;
                end
            end
            S_RD: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (op == rte_pkg::OP_READ) begin
                    o_cmd.set_hit = 1'b1;
                    o_cmd.hit_idx = '0;
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end else if (op == rte_pkg::OP_FIND && i_stat.match) begin
                    o_cmd.set_hit = 1'b1;
                    o_cmd.hit_idx = rte_pkg::IdxW'(r_i);
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end else if (op == rte_pkg::OP_REMOVE_HOP && i_stat.match) begin
                    // move last entry here, then check this slot again
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_addr = rte_pkg::IdxW'(cnt - 1'b1);
                    n_state = S_MVRD;
                end else begin
                    if (i_stat.match && op != rte_pkg::OP_FIND) begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wr_addr = rte_pkg::IdxW'(r_i);
                        o_cmd.wr_sel = rte_pkg::WSEL_MOD;
                    end
                    last_ok = (r_i + 1'b1 >= cnt);
                    if (last_ok) begin
                        o_cmd.done = 1'b1;
                        o_cmd.status = (op == rte_pkg::OP_FIND) ?
                                       rte_pkg::ST_NOT_FOUND : rte_pkg::ST_OK;
                        n_state = S_IDLE;
                    end else begin
                        n_i = r_i + 1'b1;
                        o_cmd.rd_en = 1'b1;
                        o_cmd.rd_addr = rte_pkg::IdxW'(r_i + 1'b1);
                        n_state = S_RD;
                    end
                end
            end
            S_MVRD: begin
                n_state = S_MVWR;
            end
            S_MVWR: begin
                o_cmd.hold_last = 1'b1;
                o_cmd.cnt_dec = 1'b1;
                o_cmd.wr_en = (r_i != cnt - 1'b1);
                o_cmd.wr_addr = rte_pkg::IdxW'(r_i);
                o_cmd.wr_sel = rte_pkg::WSEL_MOD;
                if (op == rte_pkg::OP_REMOVE || r_i >= cnt - 1'b1) begin
                    o_cmd.done = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // recheck slot i after the write lands
                    n_state = S_RECHK;
                end
            end
            S_RECHK: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_addr = rte_pkg::IdxW'(r_i);
                n_state = S_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_busy_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_busy)
        else $error("busy after reset");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> !o_busy)
        else $error("still busy after done");
    a_cnt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.cnt_inc && o_cmd.cnt_dec))
        else $error("count inc and dec together");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.count <= rte_pkg::CntW'(rte_pkg::Depth))
        else $error("count above depth");
`endif
endmodule

### src/route_table_engine_top.sv
// ----------------------------------------------------------------------------
// route_table_engine_top
// Route table engine: controller and datapath around one table memory.
// ----------------------------------------------------------------------------
// load/append/out-of-range finish in DISP; read goes DISP, RD, EVAL; remove index
// goes DISP, MVRD, MVWR; find and scans by network or hop read one entry at a time
// via RD and EVAL; remove by hop adds MVRD, MVWR, RECHK per removed entry
// one request at a time; busy stays high until the result strobe
// synchronous reset clears count and control; table contents are not cleared
module route_table_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_opcode,
    input  logic [31:0] i_address_in,
    input  logic [5:0]  i_prefix_in,
    input  logic [31:0] i_distance_in,
    input  logic [31:0] i_hop_in,
    input  logic [5:0]  i_entry_index,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [5:0]  o_hit_index,
    output logic [31:0] o_net_out,
    output logic [5:0]  o_prefix_out,
    output logic [31:0] o_distance_out,
    output logic        o_via_out,
    output logic [31:0] o_hop_out,
    output logic        o_disabled_out,
    output logic [6:0]  o_count_out
);
    rte_pkg::t_cmd cmd;
    rte_pkg::t_stat stat;

    rte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rte_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_opcode),
        .i_address_in   (i_address_in),
        .i_prefix_in    (i_prefix_in),
        .i_distance_in  (i_distance_in),
        .i_hop_in       (i_hop_in),
        .i_entry_index  (i_entry_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_hit_index    (o_hit_index),
        .o_net_out      (o_net_out),
        .o_prefix_out   (o_prefix_out),
        .o_distance_out (o_distance_out),
        .o_via_out      (o_via_out),
        .o_hop_out      (o_hop_out),
        .o_disabled_out (o_disabled_out),
        .o_count_out    (o_count_out)
    );
endmodule
